// ===== rtl/uvs_pkg.sv =====
// shared types and constants for the uv sphere mesh generator
package uvs_pkg;

  // cordic rotation count and gain pre-compensation (0.60725 in q30)
  localparam int ROT_STEPS = 24;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  // record kind codes on the output
  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_NONE     = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // input transfer, apply restart
    logic decide;      // latch grid point, choose tick type, step counters
    logic div_theta;   // start divider on the column angle
    logic div_phi;     // start divider on the ring angle
    logic cord_start;  // start cordic on the divider quotient
    logic save_theta;  // store column cos/sin
    logic save_phi;    // store ring cos/sin
    logic mul_x;       // product cos(theta)*sin(phi)
    logic mul_y;       // format x, product sin(theta)*sin(phi)
    logic fmt;         // format y and z
    logic load_out;    // load current record into the output register
  } uvs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic finished;
    logic poles;
    logic div_busy;
    logic cord_busy;
    logic rec_last;
  } uvs_stat_t;

  // arctangent of 2^-k in 2^32 units per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] v;
    unique case (k)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/uv_sphere_mesh_generator.sv =====
// uv sphere mesh generator: grid-point ticks in, vertex and triangle records out
// a grid tick runs the divider and then the cordic for the column angle, then both again for
//   the ring angle, then the two products and the formatting steps before its first record
// a pole or finished tick goes from the decide step straight to its records; records then leave
//   at one per cycle while the output side takes them, and the next input transfer
//   can come in the cycle after the last record is loaded, so the shared divider and cordic set throughput
// reset (rst, synchronous) restores segment count 16, column 0, ring 1, flags clear
module uv_sphere_mesh_generator
  import uvs_pkg::*;
#(
  parameter int MAX_SEGMENTS    = 256,
  parameter int ANGLE_BITS      = 16,
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         record_kind,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic [15:0]        corner_a,
  output logic [15:0]        corner_b,
  output logic [15:0]        corner_c,
  output logic               last_of_tick,
  output logic               mesh_done
);

  uvs_cmd_t  cmd;
  uvs_stat_t stat;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  uvs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  uvs_datapath #(
    .MAX_SEGMENTS    (MAX_SEGMENTS),
    .ANGLE_BITS      (ANGLE_BITS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .restart      (restart),
    .record_kind  (record_kind),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .last_of_tick (last_of_tick),
    .mesh_done    (mesh_done)
  );

endmodule

// ===== rtl/uvs_cordic.sv =====
// iterative cordic, one rotation per cycle, cos and sin in q30
module uvs_cordic
  import uvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               busy,
  output logic signed [31:0] cos_out,
  output logic signed [31:0] sin_out
);

  logic signed [31:0] x, y;
  logic signed [33:0] z;
  logic [4:0]         k;
  logic               flip;

  // fold into the right half plane
  logic               fold;
  logic [31:0]        folded;
  assign fold   = angle[31] ^ angle[30];
  assign folded = {angle[31] ^ fold, angle[30:0]};

  // one rotation step
  logic signed [31:0] dx, dy;
  logic signed [33:0] dz;
  assign dx = y >>> k;
  assign dy = x >>> k;
  assign dz = $signed({2'b00, atan_turn(k)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && k == 5'(ROT_STEPS - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= 32'sd0;
      z    <= 34'(signed'(folded));
      k    <= 5'd0;
      flip <= fold;
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - dz;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + dz;
      end
      k <= k + 5'd1;
    end
  end

  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;

endmodule

// ===== rtl/uvs_datapath.sv =====
// walk counters, angle divider, cordic, products and record formatting
module uvs_datapath
  import uvs_pkg::*;
#(
  parameter int MAX_SEGMENTS    = 256,
  parameter int ANGLE_BITS      = 16,
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  uvs_cmd_t           cmd,
  output uvs_stat_t          stat,
  input  logic               cfg_write,
  input  logic [8:0]         cfg_data,
  input  logic               restart,
  output logic [1:0]         record_kind,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic [15:0]        corner_a,
  output logic [15:0]        corner_b,
  output logic [15:0]        corner_c,
  output logic               last_of_tick,
  output logic               mesh_done
);

  localparam int CW   = $clog2(MAX_SEGMENTS);
  localparam int SW   = $clog2(MAX_SEGMENTS + 1);
  localparam int DENW = SW + 1;
  localparam int NW   = CW + ANGLE_BITS + 1;
  localparam int DCW  = $clog2(NW + 1);
  localparam int SH_XY = 60 - COORD_FRAC_BITS;
  localparam int SH_Z  = 30 - COORD_FRAC_BITS;
  localparam logic signed [63:0] LIM = 64'sd1 <<< COORD_FRAC_BITS;

  // record sequence codes within one tick
  localparam logic [2:0] R_TOP  = 3'd0;
  localparam logic [2:0] R_VERT = 3'd1;
  localparam logic [2:0] R_Q1   = 3'd2;
  localparam logic [2:0] R_Q2   = 3'd3;
  localparam logic [2:0] R_BOT  = 3'd4;
  localparam logic [2:0] R_PN   = 3'd5;
  localparam logic [2:0] R_PS   = 3'd6;
  localparam logic [2:0] R_NONE = 3'd7;

  // clamp to the coordinate range, then to 16 bits
  function automatic logic [15:0] fit_coord(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v;
    if (t > LIM) t = LIM;
    if (t < -LIM) t = -LIM;
    if (t > 64'sd32767) t = 64'sd32767;
    if (t < -64'sd32768) t = -64'sd32768;
    return t[15:0];
  endfunction

  // configuration register and clamped count
  logic [8:0]    seg_reg;
  logic [SW-1:0] s, m;
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_reg <= 9'd16;
    end else if (cfg_write) begin
      seg_reg <= cfg_data;
    end
  end
  always_comb begin
    if (seg_reg < 9'd3) s = SW'(3);
    else if (32'(seg_reg) > MAX_SEGMENTS) s = SW'(MAX_SEGMENTS);
    else s = SW'(seg_reg);
    m = s - SW'(1);
  end

  // walk state
  logic [CW-1:0] column_counter, ring_counter;
  logic          poles_pending, finished_flag;
  logic [SW-1:0] jc;
  logic [SW-1:0] i_ext, i_inc;
  always_comb begin
    i_ext = SW'(column_counter);
    i_inc = i_ext + SW'(1);
    if (ring_counter == '0) jc = SW'(1);
    else if (SW'(ring_counter) > m) jc = m;
    else jc = SW'(ring_counter);
  end

  logic grid_now;
  assign grid_now = !finished_flag && !poles_pending && (i_ext < s);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      ring_counter   <= CW'(1);
      poles_pending  <= 1'b0;
      finished_flag  <= 1'b0;
    end else if (cmd.accept && restart) begin
      column_counter <= '0;
      ring_counter   <= CW'(1);
      poles_pending  <= 1'b0;
      finished_flag  <= 1'b0;
    end else if (cmd.decide && !finished_flag) begin
      if (!grid_now) begin
        poles_pending <= 1'b0;
        finished_flag <= 1'b1;
      end else if (jc >= m) begin
        ring_counter <= CW'(1);
        if (i_inc >= s) begin
          poles_pending  <= 1'b1;
          column_counter <= '0;
        end else begin
          column_counter <= CW'(i_inc);
        end
      end else begin
        ring_counter <= CW'(jc + SW'(1));
      end
    end
  end

  // latched grid point
  logic [SW-1:0] lj, ls;
  logic [15:0]   ltop, lbase, lnext;
  logic          inner;
  logic [2:0]    cur_rec;
  logic [SW-1:0] nxt_col;
  assign nxt_col = (i_inc == s) ? '0 : i_inc;

  function automatic logic [2:0] rec_next(input logic [2:0] r, input logic in_ring);
    logic [2:0] n;
    unique case (r)
      R_TOP:   n = R_VERT;
      R_VERT:  n = in_ring ? R_Q1 : R_BOT;
      R_Q1:    n = R_Q2;
      R_PN:    n = R_PS;
      default: n = R_NONE;
    endcase
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      lj    <= jc;
      ls    <= s;
      inner <= jc < m;
      ltop  <= 16'(16'(s) * 16'(m));
      lbase <= 16'(16'(i_ext) * 16'(m));
      lnext <= 16'(16'(nxt_col) * 16'(m));
      if (finished_flag) cur_rec <= R_NONE;
      else if (!grid_now) cur_rec <= R_PN;
      else cur_rec <= (jc == SW'(1)) ? R_TOP : R_VERT;
    end else if (cmd.load_out) begin
      cur_rec <= rec_next(cur_rec, inner);
    end
  end

  // serial restoring divider, one quotient bit per cycle
  logic [NW-1:0]         dnum;
  logic [DENW-1:0]       dden, drem;
  logic [ANGLE_BITS-1:0] dq;
  logic [DCW-1:0]        dcnt;
  logic [DENW:0]         rem_sh;
  logic                  qbit;
  assign rem_sh = {drem, dnum[NW-1]};
  assign qbit   = rem_sh >= {1'b0, dden};

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_theta || cmd.div_phi) begin
      dcnt <= DCW'(NW);
    end else if (dcnt != '0) begin
      dcnt <= dcnt - DCW'(1);
    end
  end

  // the column angle starts in the decide step, so it takes the live counter and count
  always_ff @(posedge clk) begin
    if (cmd.div_theta) begin
      dnum <= NW'({column_counter, {ANGLE_BITS{1'b0}}}) + NW'(s >> 1);
      dden <= DENW'(s);
      drem <= '0;
    end else if (cmd.div_phi) begin
      dnum <= NW'({lj, {ANGLE_BITS{1'b0}}}) + NW'(ls);
      dden <= {ls, 1'b0};
      drem <= '0;
    end else if (dcnt != '0) begin
      drem <= qbit ? DENW'(rem_sh - {1'b0, dden}) : rem_sh[DENW-1:0];
      dnum <= {dnum[NW-2:0], 1'b0};
      dq   <= {dq[ANGLE_BITS-2:0], qbit};
    end
  end

  // shared cordic
  logic               cord_busy;
  logic signed [31:0] cord_cos, cord_sin;
  uvs_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.cord_start),
    .angle   ({dq, {(32 - ANGLE_BITS){1'b0}}}),
    .busy    (cord_busy),
    .cos_out (cord_cos),
    .sin_out (cord_sin)
  );

  // trig results, products and formatted position
  logic signed [31:0] ct, st, cp, sp;
  logic signed [63:0] prod;
  logic [15:0]        px, py, pz;
  always_ff @(posedge clk) begin
    if (cmd.save_theta) begin
      ct <= cord_cos;
      st <= cord_sin;
    end
    if (cmd.save_phi) begin
      cp <= cord_cos;
      sp <= cord_sin;
    end
    if (cmd.mul_x) prod <= ct * sp;
    if (cmd.mul_y) begin
      px   <= fit_coord((prod + (64'sd1 <<< (SH_XY - 1))) >>> SH_XY);
      prod <= st * sp;
    end
    if (cmd.fmt) begin
      py <= fit_coord((prod + (64'sd1 <<< (SH_XY - 1))) >>> SH_XY);
      pz <= fit_coord((64'(cp) + (64'sd1 <<< (SH_Z - 1))) >>> SH_Z);
    end
  end

  // output record register
  logic [15:0] lj16, ls16;
  assign lj16 = 16'(lj);
  assign ls16 = 16'(ls);
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      record_kind  <= KIND_TRIANGLE;
      pos_x        <= '0;
      pos_y        <= '0;
      pos_z        <= '0;
      corner_a     <= '0;
      corner_b     <= '0;
      corner_c     <= '0;
      last_of_tick <= stat.rec_last;
      mesh_done    <= 1'b0;
      unique case (cur_rec)
        R_TOP: begin
          corner_a <= ltop;
          corner_b <= lbase;
          corner_c <= lnext;
        end
        R_VERT: begin
          record_kind <= KIND_VERTEX;
          pos_x <= px;
          pos_y <= py;
          pos_z <= pz;
        end
        R_Q1: begin
          corner_a <= lbase + lj16 - 16'd1;
          corner_b <= lbase + lj16;
          corner_c <= lnext + lj16 - 16'd1;
        end
        R_Q2: begin
          corner_a <= lbase + lj16;
          corner_b <= lnext + lj16;
          corner_c <= lnext + lj16 - 16'd1;
        end
        R_BOT: begin
          corner_a <= lbase + ls16 - 16'd2;
          corner_b <= ltop + 16'd1;
          corner_c <= lnext + ls16 - 16'd2;
        end
        R_PN: begin
          record_kind <= KIND_VERTEX;
          pos_z <= fit_coord(LIM);
        end
        R_PS: begin
          record_kind <= KIND_VERTEX;
          pos_z     <= fit_coord(-LIM);
          mesh_done <= 1'b1;
        end
        R_NONE: begin
          record_kind <= KIND_NONE;
          mesh_done   <= 1'b1;
        end
      endcase
    end
  end

  // status
  assign stat.finished  = finished_flag;
  assign stat.poles     = !grid_now;
  assign stat.div_busy  = dcnt != '0;
  assign stat.cord_busy = cord_busy;
  assign stat.rec_last  = (cur_rec == R_Q2) || (cur_rec == R_BOT) ||
                          (cur_rec == R_PS) || (cur_rec == R_NONE);

endmodule

// ===== rtl/uvs_ctrl.sv =====
// controller state machine: sequences a tick and the output transfers
module uvs_ctrl
  import uvs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  uvs_stat_t stat,
  output uvs_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_DIV_T  = 4'd2;
  localparam logic [3:0] S_CORD_T = 4'd3;
  localparam logic [3:0] S_DIV_P  = 4'd4;
  localparam logic [3:0] S_CORD_P = 4'd5;
  localparam logic [3:0] S_MUL_X  = 4'd6;
  localparam logic [3:0] S_MUL_Y  = 4'd7;
  localparam logic [3:0] S_FMT    = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0] state, state_next;
  logic       out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.finished || stat.poles) begin
          state_next = S_EMIT;
        end else begin
          cmd.div_theta = 1'b1;
          state_next = S_DIV_T;
        end
      end
      S_DIV_T: begin
        if (!stat.div_busy) begin
          cmd.cord_start = 1'b1;
          state_next = S_CORD_T;
        end
      end
      S_CORD_T: begin
        if (!stat.cord_busy) begin
          cmd.save_theta = 1'b1;
          cmd.div_phi = 1'b1;
          state_next = S_DIV_P;
        end
      end
      S_DIV_P: begin
        if (!stat.div_busy) begin
          cmd.cord_start = 1'b1;
          state_next = S_CORD_P;
        end
      end
      S_CORD_P: begin
        if (!stat.cord_busy) begin
          cmd.save_phi = 1'b1;
          state_next = S_MUL_X;
        end
      end
      S_MUL_X: begin
        cmd.mul_x = 1'b1;
        state_next = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd.mul_y = 1'b1;
        state_next = S_FMT;
      end
      S_FMT: begin
        cmd.fmt = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          if (stat.rec_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // a record is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output record overwritten");

  // an input transfer is always followed by the decide step
  a_accept_decide: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_DECIDE)
    else $error("decide step skipped");

  // the divider is never restarted while it runs
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_theta || cmd.div_phi) |-> !stat.div_busy)
    else $error("divider restarted while busy");

  // the cordic is never restarted while it runs
  a_cord_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.cord_start |-> !stat.cord_busy)
    else $error("cordic restarted while busy");

endmodule
